### src/ppwm_pkg.sv
// Shared types and constants for the position PID / soft PWM core.
// Holds beat structs, configuration struct and register indexes; no dependencies.
package ppwm_pkg;

  localparam int GainFracBitsDef = 8;
  localparam int PosWidthDef     = 32;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 31;

  localparam logic [CfgIdxW-1:0] CfgGainP     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGainI     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgGainD     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSampleTks = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPwmTks    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgIntLimit  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgRunEn     = 3'd6;

  typedef struct packed {
    logic signed [31:0] position_count;
    logic signed [31:0] target_position;
  } in_beat_t;

  typedef struct packed {
    logic               pin_forward;
    logic               pin_reverse;
    logic [15:0]        duty_value;
    logic               drive_direction;
    logic               sample_taken;
    logic signed [31:0] position_error;
  } out_beat_t;

  typedef struct packed {
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic [15:0]        sample_ticks;
    logic [15:0]        pwm_ticks;
    logic [30:0]        integral_limit;
    logic               run_enable;
  } cfg_t;

endpackage

### src/ppwm_regs.sv
// Configuration register file for the position PID / soft PWM core.
// Depends on ppwm_pkg (cfg_t, register indexes).
module ppwm_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ppwm_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [ppwm_pkg::CfgDataW-1:0]      cfg_wdata_i,
  output ppwm_pkg::cfg_t                     cfg_o
);

  ppwm_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p         <= 16'sd256;
      cfg_q.gain_i         <= 16'sd0;
      cfg_q.gain_d         <= 16'sd0;
      cfg_q.sample_ticks   <= 16'd500;
      cfg_q.pwm_ticks      <= 16'd200;
      cfg_q.integral_limit <= 31'd100;
      cfg_q.run_enable     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ppwm_pkg::CfgGainP:     cfg_q.gain_p         <= cfg_wdata_i[15:0];
        ppwm_pkg::CfgGainI:     cfg_q.gain_i         <= cfg_wdata_i[15:0];
        ppwm_pkg::CfgGainD:     cfg_q.gain_d         <= cfg_wdata_i[15:0];
        ppwm_pkg::CfgSampleTks: cfg_q.sample_ticks   <= cfg_wdata_i[15:0];
        ppwm_pkg::CfgPwmTks:    cfg_q.pwm_ticks      <= cfg_wdata_i[15:0];
        ppwm_pkg::CfgIntLimit:  cfg_q.integral_limit <= cfg_wdata_i[30:0];
        ppwm_pkg::CfgRunEn:     cfg_q.run_enable     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/ppwm_in_stage.sv
// Input register of the core: captures a tick and the saturated position error.
// Depends on ppwm_pkg (in_beat_t).
module ppwm_in_stage #(
  parameter int POS_WIDTH = ppwm_pkg::PosWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ppwm_pkg::in_beat_t  in_data_i,
  input  logic                take_i,
  output logic                valid_o,
  output logic signed [31:0]  err_o
);

  logic               valid_q;
  logic signed [31:0] err_q, err_d;
  logic signed [32:0] pos_ext, tgt_ext, diff;
  logic               load;

  // operands are POS_WIDTH-bit two's complement, widened to 33 bits
  assign pos_ext = {{(33-POS_WIDTH){in_data_i.position_count[POS_WIDTH-1]}},
                    in_data_i.position_count[POS_WIDTH-1:0]};
  assign tgt_ext = {{(33-POS_WIDTH){in_data_i.target_position[POS_WIDTH-1]}},
                    in_data_i.target_position[POS_WIDTH-1:0]};
  assign diff    = tgt_ext - pos_ext;

  always_comb begin
    if (diff[32] != diff[31]) begin
      err_d = diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      err_d = diff[31:0];
    end
  end

  assign load       = in_valid_i && (!valid_q || take_i);
  assign in_stall_o = valid_q && !take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      err_q <= err_d;
    end
  end

  assign valid_o = valid_q;
  assign err_o   = err_q;

endmodule

### src/ppwm_update.sv
// Controller state, PID update, PWM step and result register.
// Depends on ppwm_pkg (cfg_t, out_beat_t).
module ppwm_update #(
  parameter int GAIN_FRAC_BITS = ppwm_pkg::GainFracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ppwm_pkg::cfg_t      cfg_i,
  input  logic                valid_i,
  input  logic signed [31:0]  err_i,
  output logic                take_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ppwm_pkg::out_beat_t out_data_o
);

  localparam int AccW = 51;
  localparam logic signed [AccW-1:0] RoundBias =
    (AccW'(1) << GAIN_FRAC_BITS) - AccW'(1);

  logic [15:0]        smp_cnt_q, smp_cnt_d;
  logic [15:0]        pwm_cnt_q, pwm_cnt_d;
  logic signed [31:0] sum_q, sum_d;
  logic signed [31:0] prev_q, prev_d;
  logic [15:0]        duty_q, duty_d;
  logic               dir_q, dir_d;
  logic               fwd_q, fwd_d;
  logic               rev_q, rev_d;
  logic               out_valid_q;
  ppwm_pkg::out_beat_t out_q, out_d;

  logic               run;
  logic [15:0]        smp_inc, pwm_inc;
  logic               sample;
  logic signed [32:0] sum_raw, lim_pos, lim_neg, diff;
  logic signed [31:0] sum_clamped;
  logic signed [47:0] prod_p, prod_i;
  logic signed [48:0] prod_d;
  logic signed [AccW-1:0] acc, acc_rnd, quot;
  logic [AccW-1:0]    mag;
  logic               acc_pos;
  logic [15:0]        duty_new;

  assign take_o = valid_i && (!out_valid_q || !out_stall_i);
  assign run    = take_o && cfg_i.run_enable;

  // error sum with symmetric anti-windup clamp
  assign lim_pos = $signed({2'b00, cfg_i.integral_limit});
  assign lim_neg = -lim_pos;
  assign sum_raw = 33'(sum_q) + 33'(err_i);
  always_comb begin
    if (sum_raw > lim_pos) begin
      sum_clamped = lim_pos[31:0];
    end else if (sum_raw < lim_neg) begin
      sum_clamped = lim_neg[31:0];
    end else begin
      sum_clamped = sum_raw[31:0];
    end
  end

  assign diff   = 33'(err_i) - 33'(prev_q);
  assign prod_p = 48'(cfg_i.gain_p) * 48'(err_i);
  assign prod_i = 48'(cfg_i.gain_i) * 48'(sum_clamped);
  assign prod_d = 49'(cfg_i.gain_d) * 49'(diff);
  assign acc    = AccW'(prod_p) + AccW'(prod_i) + AccW'(prod_d);

  // divide by 2^frac, truncating toward zero
  assign acc_rnd = acc + (acc[AccW-1] ? RoundBias : '0);
  assign quot    = acc_rnd >>> GAIN_FRAC_BITS;
  assign acc_pos = !quot[AccW-1] && (quot != '0);
  assign mag     = acc_pos ? quot : -quot;
  assign duty_new = (mag > AccW'(cfg_i.pwm_ticks)) ? cfg_i.pwm_ticks : mag[15:0];

  assign smp_inc = smp_cnt_q + 16'd1;
  assign sample  = smp_inc >= cfg_i.sample_ticks;
  assign pwm_inc = (pwm_cnt_q == 16'hFFFF) ? pwm_cnt_q : pwm_cnt_q + 16'd1;

  always_comb begin
    smp_cnt_d = smp_cnt_q;
    pwm_cnt_d = pwm_cnt_q;
    sum_d     = sum_q;
    prev_d    = prev_q;
    duty_d    = duty_q;
    dir_d     = dir_q;
    fwd_d     = fwd_q;
    rev_d     = rev_q;
    if (run) begin
      smp_cnt_d = sample ? 16'd0 : smp_inc;
      if (sample) begin
        sum_d  = sum_clamped;
        prev_d = err_i;
        duty_d = duty_new;
        dir_d  = !acc_pos;
      end
      pwm_cnt_d = pwm_inc;
      // period restart drives one pin and releases the other
      if (pwm_inc >= cfg_i.pwm_ticks && duty_d != 16'd0) begin
        pwm_cnt_d = 16'd0;
        fwd_d     = !dir_d;
        rev_d     = dir_d;
      end else if (pwm_inc >= duty_d) begin
        fwd_d = 1'b0;
        rev_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_d.pin_forward     = fwd_d;
    out_d.pin_reverse     = rev_d;
    out_d.duty_value      = duty_d;
    out_d.drive_direction = dir_d;
    out_d.sample_taken    = run && sample;
    out_d.position_error  = prev_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_cnt_q   <= '0;
      pwm_cnt_q   <= '0;
      sum_q       <= '0;
      prev_q      <= '0;
      duty_q      <= '0;
      dir_q       <= 1'b0;
      fwd_q       <= 1'b0;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      smp_cnt_q <= smp_cnt_d;
      pwm_cnt_q <= pwm_cnt_d;
      sum_q     <= sum_d;
      prev_q    <= prev_d;
      duty_q    <= duty_d;
      dir_q     <= dir_d;
      fwd_q     <= fwd_d;
      rev_q     <= rev_d;
      if (take_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### src/position_pid_with_soft_pwm_core.sv
// Position PID with soft PWM for an H-bridge: one result beat per tick beat.
// A tick enters an input register (error computed there), then one pass through the
// PID update and PWM step lands in the result register. A tick can be taken every
// cycle while the result register is not stalled. Each pass updates the error
// sum, three 16-bit gain products and the PWM counter together in a single step.
// The user must write registers only while no beat is in flight (not enforced).
// Depends on ppwm_pkg, ppwm_regs, ppwm_in_stage, ppwm_update.
module position_pid_with_soft_pwm_core #(
  parameter int GAIN_FRAC_BITS = ppwm_pkg::GainFracBitsDef,
  parameter int POS_WIDTH      = ppwm_pkg::PosWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ppwm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ppwm_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ppwm_pkg::in_beat_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ppwm_pkg::out_beat_t           out_data_o
);

  ppwm_pkg::cfg_t     cfg;
  logic               s1_valid;
  logic signed [31:0] s1_err;
  logic               take;

  ppwm_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ppwm_in_stage #(
    .POS_WIDTH (POS_WIDTH)
  ) u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .take_i     (take),
    .valid_o    (s1_valid),
    .err_o      (s1_err)
  );

  ppwm_update #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .valid_i     (s1_valid),
    .err_i       (s1_err),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
